/* src/sbe_pkg.sv */
// sbe_pkg: shared types and constants for the sixel band encoder
// no dependencies
`default_nettype none
package sbe_pkg;
    localparam int unsigned BAND_ROWS  = 6;
    localparam int unsigned SIXEL_BIAS = 63;
    localparam int unsigned NUM_COLORS = 256;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_EMIT  = 2'd2;

    localparam logic [6:0] CH_HASH   = 7'h23;
    localparam logic [6:0] CH_DOLLAR = 7'h24;
    localparam logic [6:0] CH_DASH   = 7'h2d;
    localparam logic [6:0] CH_LF     = 7'h0a;
    localparam logic [6:0] CH_ZERO   = 7'h30;

    typedef enum logic [1:0] {
        PH_SEARCH   = 2'd0,
        PH_COLUMNS  = 2'd1,
        PH_LINE_END = 2'd2,
        PH_BAND_END = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_SEARCH,
        ST_COL_READ,
        ST_COL_WAIT,
        ST_PUT,
        ST_CLEAR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input word
        logic fill_start; // start rectangle walk
        logic fill_step;  // write one pixel and advance
        logic search_step;// test one colour bit and advance
        logic col_start;  // start reading a column
        logic col_step;   // read one row of the column
        logic build_token;// form token bytes from phase
        logic put_next;   // advance byte pointer
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_done;
        logic search_end;
        logic col_done;
        logic put_last;
    } dp_status_t;
endpackage
`default_nettype wire

/* src/sbe_datapath.sv */
// sbe_datapath: frame memory, colour map, cursors and token byte buffer
// depends on sbe_pkg
`default_nettype none
module sbe_datapath #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [8:0]         image_width,
    input  wire logic [8:0]         image_height,
    input  wire logic [1:0]         kind,
    input  wire logic [7:0]         color_index,
    input  wire logic [7:0]         left_col,
    input  wire logic [7:0]         top_row,
    input  wire logic [7:0]         right_col,
    input  wire logic [7:0]         bottom_row,
    input  wire sbe_pkg::dp_cmd_t   cmd,
    output sbe_pkg::dp_status_t     status,
    output logic [1:0]              kind_q,
    output logic                    walk_ok,
    output logic                    col_phase,
    output logic [6:0]              text_byte,
    output logic                    frame_end
);
    import sbe_pkg::*;

    localparam int unsigned XW = $clog2(MAX_WIDTH);
    localparam int unsigned YW = $clog2(MAX_HEIGHT);
    localparam int unsigned AW = XW + YW;
    localparam int unsigned BW = $clog2(MAX_HEIGHT / 6 + 1);

    logic [7:0] mem [0:(1 << AW) - 1];
    logic [7:0] rd_reg;
    logic [NUM_COLORS-1:0] used_reg;

    logic [1:0] kind_reg;
    logic [7:0] color_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic [7:0] fx_reg, fy_reg;

    logic [BW-1:0] band_reg;
    logic [8:0]    ccur_reg;
    logic [8:0]    col_reg;
    phase_t        phase_reg;
    logic [2:0]    k_reg;
    logic [2:0]    kd_reg;
    logic          rdv_reg;
    logic [5:0]    bits_reg;

    logic [6:0] buf_reg [0:3];
    logic [1:0] cnt_reg, ptr_reg;
    logic       fend_reg;

    logic [8:0] w_eff, h_eff;
    always_comb
    begin
        w_eff = (image_width == 9'd0) ? 9'd1 :
                (32'(image_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : image_width;
        h_eff = (image_height == 9'd0) ? 9'd1 :
                (32'(image_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : image_height;
    end

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [12:0] row_base;
    logic [12:0] row_now;
    logic in_frame, fill_ok;

    assign in_frame = ({1'b0, x1_reg} < w_eff) && ({1'b0, y1_reg} < h_eff);
    assign fill_ok  = in_frame && ({1'b0, x2_reg} < w_eff) && ({1'b0, y2_reg} < h_eff)
                      && (x1_reg <= x2_reg) && (y1_reg <= y2_reg);
    assign row_base = 13'(band_reg) * 13'd6;
    assign row_now  = row_base + 13'(k_reg);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = AW'({fy_reg, fx_reg});
        if (cmd.fill_step)
            wr_en = 1'b1;
        wr_addr = AW'((AW'(fy_reg) << XW) | AW'(fx_reg));
        rd_addr = AW'((AW'(row_now) << XW) | AW'(col_reg));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= color_reg;
        rd_reg <= mem[rd_addr];
    end

    // colour search
    logic hit_now;
    assign hit_now = !ccur_reg[8] && used_reg[ccur_reg[7:0]];

    // decimal digits of colour
    logic [7:0] c8;
    logic [1:0] d100;
    logic [7:0] rem100;
    logic [3:0] d10, d1;
    always_comb
    begin
        c8 = ccur_reg[7:0];
        d100 = (c8 >= 8'd200) ? 2'd2 : (c8 >= 8'd100) ? 2'd1 : 2'd0;
        rem100 = c8 - 8'(d100) * 8'd100;
        d10 = 4'((16'(rem100) * 16'd205) >> 11);
        d1 = 4'(rem100 - 8'(d10) * 8'd10);
    end

    logic band_last;
    assign band_last = ((13'(band_reg) + 13'd1) * 13'd6) >= 13'(h_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            band_reg  <= '0;
            ccur_reg  <= '0;
            col_reg   <= '0;
            phase_reg <= PH_SEARCH;
            cnt_reg   <= '0;
            ptr_reg   <= '0;
            fend_reg  <= 1'b0;
            kind_reg  <= '0;
            rdv_reg   <= 1'b0;
            k_reg     <= '0;
            kd_reg    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg  <= kind;
                color_reg <= color_index;
                x1_reg    <= left_col;
                y1_reg    <= top_row;
                x2_reg    <= right_col;
                y2_reg    <= bottom_row;
                fx_reg    <= left_col;
                fy_reg    <= top_row;
            end
            if (cmd.fill_step)
            begin
                used_reg[color_reg] <= 1'b1;
                if (fx_reg == x2_reg || kind_reg == KIND_PIXEL)
                begin
                    fx_reg <= x1_reg;
                    fy_reg <= fy_reg + 8'd1;
                end
                else
                    fx_reg <= fx_reg + 8'd1;
            end
            if (cmd.search_step && !hit_now && !ccur_reg[8])
                ccur_reg <= ccur_reg + 9'd1;
            if (cmd.col_start)
            begin
                k_reg    <= '0;
                rdv_reg  <= 1'b0;
                bits_reg <= '0;
            end
            if (cmd.col_step)
            begin
                rdv_reg <= (row_now < 13'(h_eff)) && (k_reg < 3'd6);
                kd_reg  <= k_reg;
                if (k_reg != 3'd6)
                    k_reg <= k_reg + 3'd1;
                if (rdv_reg && rd_reg == ccur_reg[7:0])
                    bits_reg[kd_reg] <= 1'b1;
            end
            if (cmd.build_token)
            begin
                ptr_reg  <= '0;
                fend_reg <= 1'b0;
                case (phase_reg)
                    PH_SEARCH:
                    begin
                        if (ccur_reg[8])
                        begin
                            buf_reg[0] <= CH_DASH;
                            buf_reg[1] <= CH_LF;
                            cnt_reg    <= 2'd1;
                            fend_reg   <= band_last;
                            band_reg   <= band_last ? '0 : band_reg + BW'(1);
                            ccur_reg   <= '0;
                            col_reg    <= '0;
                        end
                        else
                        begin
                            buf_reg[0] <= CH_HASH;
                            if (c8 >= 8'd100)
                            begin
                                buf_reg[1] <= CH_ZERO + 7'(d100);
                                buf_reg[2] <= CH_ZERO + 7'(d10);
                                buf_reg[3] <= CH_ZERO + 7'(d1);
                                cnt_reg    <= 2'd3;
                            end
                            else if (c8 >= 8'd10)
                            begin
                                buf_reg[1] <= CH_ZERO + 7'(d10);
                                buf_reg[2] <= CH_ZERO + 7'(d1);
                                cnt_reg    <= 2'd2;
                            end
                            else
                            begin
                                buf_reg[1] <= CH_ZERO + 7'(d1);
                                cnt_reg    <= 2'd1;
                            end
                            col_reg   <= '0;
                            phase_reg <= PH_COLUMNS;
                        end
                    end
                    PH_COLUMNS:
                    begin
                        if (col_reg >= w_eff)
                        begin
                            buf_reg[0] <= CH_DOLLAR;
                            buf_reg[1] <= CH_LF;
                            cnt_reg    <= 2'd1;
                            col_reg    <= '0;
                            if (ccur_reg[7:0] == 8'hff)
                                phase_reg <= PH_BAND_END;
                            else
                            begin
                                ccur_reg  <= ccur_reg + 9'd1;
                                phase_reg <= PH_SEARCH;
                            end
                        end
                        else
                        begin
                            buf_reg[0] <= 7'(bits_reg) + 7'(SIXEL_BIAS);
                            cnt_reg    <= 2'd0;
                            col_reg    <= col_reg + 9'd1;
                            if (col_reg + 9'd1 >= w_eff)
                                phase_reg <= PH_LINE_END;
                        end
                    end
                    PH_LINE_END:
                    begin
                        buf_reg[0] <= CH_DOLLAR;
                        buf_reg[1] <= CH_LF;
                        cnt_reg    <= 2'd1;
                        col_reg    <= '0;
                        if (ccur_reg[7:0] == 8'hff)
                            phase_reg <= PH_BAND_END;
                        else
                        begin
                            ccur_reg  <= ccur_reg + 9'd1;
                            phase_reg <= PH_SEARCH;
                        end
                    end
                    default:
                    begin
                        buf_reg[0] <= CH_DASH;
                        buf_reg[1] <= CH_LF;
                        cnt_reg    <= 2'd1;
                        fend_reg   <= band_last;
                        band_reg   <= band_last ? '0 : band_reg + BW'(1);
                        ccur_reg   <= '0;
                        col_reg    <= '0;
                        phase_reg  <= PH_SEARCH;
                    end
                endcase
            end
            if (cmd.put_next)
                ptr_reg <= ptr_reg + 2'd1;
        end
    end

    assign kind_q            = kind_reg;
    assign status.fill_done  = (kind_reg == KIND_PIXEL) ? 1'b1 :
                               (fy_reg == y2_reg && fx_reg == x2_reg);
    assign status.search_end = (phase_reg != PH_SEARCH) || ccur_reg[8] || hit_now;
    assign status.col_done   = (k_reg == 3'd6) && !rdv_reg;
    assign status.put_last   = (ptr_reg == cnt_reg);
    assign text_byte         = buf_reg[ptr_reg];
    assign frame_end         = fend_reg && (ptr_reg == cnt_reg);

    logic fill_ok_q;
    assign fill_ok_q = (kind_reg == KIND_PIXEL) ? in_frame : fill_ok;
    assign walk_ok   = fill_ok_q;
    assign col_phase = (phase_reg == PH_COLUMNS);

    assert property (@(posedge clk) disable iff (!rst_n) cmd.fill_step |-> fill_ok_q)
        else $error("fill walk outside frame");
    assert property (@(posedge clk) disable iff (!rst_n) ptr_reg <= cnt_reg)
        else $error("byte pointer past token end");
    assert property (@(posedge clk) disable iff (!rst_n) k_reg <= 3'd6)
        else $error("row counter out of range");
endmodule
`default_nettype wire

/* src/sbe_control.sv */
// sbe_control: sequencing state machine for the sixel band encoder
// depends on sbe_pkg
`default_nettype none
module sbe_control (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [1:0]          kind_q,
    input  wire logic                fill_ok,
    input  wire logic                out_ready,
    input  wire logic                col_phase,
    input  wire sbe_pkg::dp_status_t status,
    output sbe_pkg::dp_cmd_t         cmd,
    output logic                     in_ready,
    output logic                     out_valid,
    output logic                     out_last
);
    import sbe_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_CLEAR;
            ST_CLEAR:
                case (kind_q)
                    KIND_PIXEL, KIND_FILL: state_next = fill_ok ? ST_FILL : ST_IDLE;
                    KIND_EMIT:             state_next = ST_SEARCH;
                    default:               state_next = ST_IDLE;
                endcase
            ST_FILL:
                if (status.fill_done)
                    state_next = ST_IDLE;
            ST_SEARCH:
                if (status.search_end)
                    state_next = col_phase ? ST_COL_READ : ST_COL_WAIT;
            ST_COL_READ:
                if (status.col_done)
                    state_next = ST_COL_WAIT;
            ST_COL_WAIT:
                state_next = ST_PUT;
            ST_PUT:
                if (out_ready && status.put_last)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        out_last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CLEAR:
                cmd.col_start = 1'b1;
            ST_FILL:
                cmd.fill_step = 1'b1;
            ST_SEARCH:
                cmd.search_step = 1'b1;
            ST_COL_READ:
                cmd.col_step = 1'b1;
            ST_COL_WAIT:
                cmd.build_token = 1'b1;
            ST_PUT:
            begin
                out_valid    = 1'b1;
                out_last     = status.put_last;
                cmd.put_next = out_ready && !status.put_last;
            end
            default:
                cmd = '0;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("accept while sending");
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.fill_step && cmd.build_token))
        else $error("fill during emit");
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == ST_PUT) |-> out_valid)
        else $error("put without valid");
endmodule
`default_nettype wire

/* src/sixel_band_encoder_top.sv */
// sixel_band_encoder_top: sixel band encoder with frame store and colour map
// depends on sbe_pkg, sbe_control, sbe_datapath
//
// channel  dir  handshake        payload
// s_axis   in   tvalid/tready    tuser=kind, tdata=colour,left,top,right,bottom
// m_axis   out  tvalid/tready    tdata=text_byte, tlast=token_last, tuser=frame_end
// cfg      in   cfg_we           cfg_index, cfg_data
// a pixel write or fill passes the clear state, then the fill state that writes its pixels;
// a rejected one goes back to idle from the clear state; an emit searches the colour map,
// reads the rows of a column byte from frame memory, then puts out the token bytes
// reset clears the colour map and cursors; frame memory is not cleared
// output stalls hold the block; no new word is taken while bytes wait
`default_nettype none
module sixel_band_encoder_top #(
    parameter int unsigned MAX_WIDTH  = 256,
    parameter int unsigned MAX_HEIGHT = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [8:0]  cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // colour, left, top, right, bottom
    input  wire logic [1:0]  s_axis_tuser,  // kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // text_byte, zero
    output logic             m_axis_tlast,  // token_last
    output logic             m_axis_tuser   // frame_end
);
    import sbe_pkg::*;

    logic [8:0] width_reg, height_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 9'd256;
            height_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'b0)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [1:0] kind_q;
    logic       walk_ok;
    logic       col_phase;
    logic [6:0] text_byte;
    logic       frame_end;

    sbe_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .clk, .rst_n,
        .image_width(width_reg), .image_height(height_reg),
        .kind(s_axis_tuser),
        .color_index(s_axis_tdata[7:0]),
        .left_col(s_axis_tdata[15:8]),
        .top_row(s_axis_tdata[23:16]),
        .right_col(s_axis_tdata[31:24]),
        .bottom_row(s_axis_tdata[39:32]),
        .cmd, .status, .kind_q, .walk_ok, .col_phase, .text_byte, .frame_end
    );

    sbe_control u_ctl (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid),
        .kind_q,
        .fill_ok(walk_ok),
        .out_ready(m_axis_tready),
        .col_phase(col_phase),
        .status,
        .cmd,
        .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, text_byte};
    assign m_axis_tuser = frame_end;
endmodule
`default_nettype wire

/* tb/sixel_band_encoder_top_test.sv */
// sixel_band_encoder_top_test: self-checking bench for the sixel band encoder
// drives pixel, fill, emit and unused-kind words and checks every text byte against a local predictor
// depends on sbe_pkg and sixel_band_encoder_top
`default_nettype none

class sixel_scoreboard;
    typedef struct {
        logic [6:0] text_byte;
        logic       token_last;
        logic       frame_end;
    } text_t;

    logic [7:0]     frame [65536];
    bit             used [256];
    int unsigned    band_idx;
    int unsigned    colour_idx;
    int unsigned    column_idx;
    sbe_pkg::phase_t phase;
    int unsigned    width_reg;
    int unsigned    height_reg;
    text_t          awaited [$];
    int             errors;

    function new();
        foreach (used[i]) used[i] = 0;
        band_idx = 0;
        colour_idx = 0;
        column_idx = 0;
        phase = sbe_pkg::PH_SEARCH;
        width_reg = 256;
        height_reg = 256;
        errors = 0;
    endfunction

    function int unsigned cols();
        if (width_reg == 0) return 1;
        return (width_reg > 256) ? 256 : width_reg;
    endfunction

    function int unsigned rows();
        if (height_reg == 0) return 1;
        return (height_reg > 256) ? 256 : height_reg;
    endfunction

    function void push_text(logic [6:0] b, logic fe);
        text_t t;
        t.text_byte = b;
        t.token_last = 1'b0;
        t.frame_end = fe;
        awaited.push_back(t);
    endfunction

    function void set_px(int unsigned r, int unsigned c, logic [7:0] colour);
        frame[r * 256 + c] = colour;
        used[colour] = 1;
    endfunction

    function void finish_band();
        bit last_band;
        last_band = (band_idx + 1) * sbe_pkg::BAND_ROWS >= rows();
        push_text(sbe_pkg::CH_DASH, 1'b0);
        push_text(sbe_pkg::CH_LF, last_band);
        band_idx = last_band ? 0 : band_idx + 1;
        colour_idx = 0;
        column_idx = 0;
        phase = sbe_pkg::PH_SEARCH;
    endfunction

    function void finish_line();
        push_text(sbe_pkg::CH_DOLLAR, 1'b0);
        push_text(sbe_pkg::CH_LF, 1'b0);
        column_idx = 0;
        if (colour_idx >= sbe_pkg::NUM_COLORS - 1)
            phase = sbe_pkg::PH_BAND_END;
        else
        begin
            colour_idx++;
            phase = sbe_pkg::PH_SEARCH;
        end
    endfunction

    function void next_token();
        int unsigned c;
        int unsigned r;
        logic [5:0] bits;
        case (phase)
            sbe_pkg::PH_SEARCH:
            begin
                c = colour_idx;
                while (c < sbe_pkg::NUM_COLORS && !used[c]) c++;
                if (c >= sbe_pkg::NUM_COLORS)
                    finish_band();
                else
                begin
                    push_text(sbe_pkg::CH_HASH, 1'b0);
                    if (c >= 100) push_text(sbe_pkg::CH_ZERO + 7'(c / 100), 1'b0);
                    if (c >= 10) push_text(sbe_pkg::CH_ZERO + 7'((c / 10) % 10), 1'b0);
                    push_text(sbe_pkg::CH_ZERO + 7'(c % 10), 1'b0);
                    colour_idx = c;
                    column_idx = 0;
                    phase = sbe_pkg::PH_COLUMNS;
                end
            end
            sbe_pkg::PH_COLUMNS:
            begin
                if (column_idx >= cols())
                    finish_line();
                else
                begin
                    bits = '0;
                    for (int k = 0; k < sbe_pkg::BAND_ROWS; k++)
                    begin
                        r = band_idx * sbe_pkg::BAND_ROWS + k;
                        if (r < rows() && frame[r * 256 + column_idx] == 8'(colour_idx))
                            bits[k] = 1'b1;
                    end
                    push_text(7'(bits) + 7'(sbe_pkg::SIXEL_BIAS), 1'b0);
                    column_idx++;
                    if (column_idx >= cols()) phase = sbe_pkg::PH_LINE_END;
                end
            end
            sbe_pkg::PH_LINE_END: finish_line();
            default: finish_band();
        endcase
    endfunction

    // note one accepted input word
    function void note_word(logic [1:0] kind, logic [7:0] colour, logic [7:0] x1,
                            logic [7:0] y1, logic [7:0] x2, logic [7:0] y2);
        int n0;
        n0 = awaited.size();
        if (kind == sbe_pkg::KIND_PIXEL)
        begin
            if (x1 < cols() && y1 < rows()) set_px(y1, x1, colour);
        end
        else if (kind == sbe_pkg::KIND_FILL)
        begin
            if (x1 < cols() && x2 < cols() && y1 < rows() && y2 < rows())
                for (int r = y1; r <= y2; r++)
                    for (int c = x1; c <= x2; c++)
                        set_px(r, c, colour);
        end
        else if (kind == sbe_pkg::KIND_EMIT)
        begin
            next_token();
            if (awaited.size() > n0) awaited[awaited.size() - 1].token_last = 1'b1;
        end
    endfunction

    task report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_text(logic [7:0] data, logic last, logic fe);
        text_t t;
        if (awaited.size() == 0)
        begin
            report("unexpected word", data, -1);
            return;
        end
        t = awaited.pop_front();
        if (data[6:0] !== t.text_byte) report("text_byte", data[6:0], t.text_byte);
        if (data[7] !== 1'b0) report("tdata pad bit", data[7], 0);
        if (last !== t.token_last) report("token_last", last, t.token_last);
        if (fe !== t.frame_end) report("frame_end", fe, t.frame_end);
    endtask
endclass

module sixel_band_encoder_top_test;
    import sbe_pkg::*;

    localparam int STALL_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [8:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;  // colour, left, top, right, bottom
    logic [1:0]  s_axis_tuser = '0;  // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;       // text_byte, zero
    logic        m_axis_tlast;       // token_last
    logic        m_axis_tuser;       // frame_end

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int          quiet_cycles = 0;
    sixel_scoreboard sb;

    sixel_band_encoder_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_text(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("sixel_band_encoder_top verification failed");
            $finish;
        end
    end

    task send_word(logic [1:0] kind, logic [7:0] colour, logic [7:0] x1,
                   logic [7:0] y1, logic [7:0] x2, logic [7:0] y2);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {y2, x2, y1, x1, colour};
        // ready is settled mid-cycle, so the next edge accepts the word
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        sb.note_word(kind, colour, x1, y1, x2, y2);
    endtask

    // hold the sender until every awaited byte has come and the block is idle
    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_reg(logic idx, logic [8:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx) sb.height_reg = value;
        else sb.width_reg = value;
    endtask

    task set_frame(logic [8:0] w, logic [8:0] h);
        drain();
        write_reg(1'b0, w);
        write_reg(1'b1, h);
        @(posedge clk);
        send_word(KIND_FILL, 8'($urandom), 8'd0, 8'd0, 8'(sb.cols() - 1), 8'(sb.rows() - 1));
    endtask

    task random_word();
        int unsigned sel;
        int unsigned x;
        int unsigned y;
        sel = $urandom_range(99);
        x = $urandom_range(0, sb.cols() - 1);
        y = $urandom_range(0, sb.rows() - 1);
        if (sel < 30)
            send_word(KIND_PIXEL, 8'($urandom), 8'(x), 8'(y), 8'($urandom), 8'($urandom));
        else if (sel < 36)
            send_word(KIND_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
        else if (sel < 42)
            send_word(KIND_FILL, 8'($urandom), 8'(x), 8'(y),
                      8'((x + $urandom_range(0, 5) < sb.cols()) ? x + $urandom_range(0, 5) : x),
                      8'((y + $urandom_range(0, 5) < sb.rows()) ? y + $urandom_range(0, 5) : y));
        else if (sel < 46)
            send_word(KIND_FILL, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
        else if (sel < 49)
            send_word(2'd3, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
        else
            send_word(KIND_EMIT, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
    endtask

    logic [8:0] phase_w [6] = '{9'd1, 9'd256, 9'd17, 9'd511, 9'd3, 9'd0};
    logic [8:0] phase_h [6] = '{9'd300, 9'd6, 9'd13, 9'd0, 9'd20, 9'd255};

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: small frame, digit counts, ignored words and rejected fills
        set_frame(9'd5, 9'd8);
        send_word(KIND_PIXEL, 8'd255, 8'd4, 8'd7, 8'd0, 8'd0);
        send_word(KIND_PIXEL, 8'd99, 8'd0, 8'd0, 8'd0, 8'd0);
        send_word(KIND_PIXEL, 8'd7, 8'd5, 8'd0, 8'd0, 8'd0);
        send_word(KIND_PIXEL, 8'd8, 8'd0, 8'd8, 8'd0, 8'd0);
        send_word(KIND_PIXEL, 8'd77, 8'd255, 8'd255, 8'd255, 8'd255);
        send_word(KIND_FILL, 8'd9, 8'd1, 8'd1, 8'd3, 8'd6);
        send_word(KIND_FILL, 8'd200, 8'd3, 8'd1, 8'd1, 8'd2);
        send_word(KIND_FILL, 8'd201, 8'd0, 8'd0, 8'd5, 8'd0);
        send_word(2'd3, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
        repeat (16) send_word(KIND_EMIT, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);

        for (int p = 0; p < 6; p++)
        begin
            set_frame(phase_w[p], phase_h[p]);
            send_idle_pct = (p < 2) ? 35 : (p < 4) ? 47 : 0;
            recv_idle_pct = (p < 2) ? 47 : (p < 4) ? 35 : 0;
            for (int i = 0; i < 85; i++)
            begin
                random_word();
                if (p == 2 && i == 40) drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("sixel_band_encoder_top verification clean");
        else
            $display("sixel_band_encoder_top verification failed");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
src/sbe_pkg.sv
src/sbe_datapath.sv
src/sbe_control.sv
src/sixel_band_encoder_top.sv
tb/sixel_band_encoder_top_test.sv
